/* hw/rtl/hte_pkg.sv */
`default_nettype none

package hte_pkg;

   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int POS_W    = 11;
   localparam int INDEX_W  = 10;
   localparam int LENGTH_W = 10;

   // frame buffer bound of the original design; limit is clamped to min(this, index cap)
   localparam int MAX_FRAME = 1024;
   localparam int INDEX_CAP = 1024;
   localparam int LIMIT_CAP = (MAX_FRAME < INDEX_CAP) ? MAX_FRAME : INDEX_CAP;

   localparam logic [POS_W-1:0]   LIMIT_CAP_POS = POS_W'(LIMIT_CAP);
   localparam logic [POS_W-1:0]   TRAILER_BYTES = POS_W'(4);
   localparam logic [POS_W-1:0]   INDEX_MAX_POS = POS_W'((1 << INDEX_W) - 1);

   // register map
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = WORD_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_WORD  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_WORD    = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_BUFFER_LIMIT = CSR_INDEX_W'(2);

   localparam logic [WORD_W-1:0] HEADER_WORD_RESET  = 16'h4040;
   localparam logic [WORD_W-1:0] TAIL_WORD_RESET    = 16'h2323;
   localparam logic [POS_W-1:0]  BUFFER_LIMIT_RESET = POS_W'(64);

   typedef struct packed {
      logic [WORD_W-1:0] header_word;
      logic [WORD_W-1:0] tail_word;
      logic [POS_W-1:0]  buffer_limit;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic [INDEX_W-1:0]  byte_index;
      logic                stored;
      logic                frame_end;
      logic [LENGTH_W-1:0] payload_length;
      logic                short_frame;
   } rsp_type;

endpackage

`default_nettype wire

/* hw/rtl/hte_if.sv */
`default_nettype none

interface hte_req_if;
   import hte_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hte_rsp_if;
   import hte_pkg::*;

   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   data_byte;
   logic [INDEX_W-1:0]  byte_index;
   logic                stored;
   logic                frame_end;
   logic [LENGTH_W-1:0] payload_length;
   logic                short_frame;

   modport source (output valid, output data_byte, output byte_index, output stored,
                   output frame_end, output payload_length, output short_frame,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_index, input stored,
                   input frame_end, input payload_length, input short_frame,
                   output ready);
endinterface

`default_nettype wire

/* hw/rtl/hte_deframer.sv */
`default_nettype none

module hte_deframer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic [hte_pkg::BYTE_W-1:0] rx_byte,
   input  wire hte_pkg::cfg_type        cfg,
   output logic                         has_result,
   output hte_pkg::rsp_type             result
);
   import hte_pkg::*;

   logic [WORD_W-1:0] shift_ff, shift_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   logic [WORD_W-1:0] shifted;
   logic [POS_W-1:0]  eff_limit;
   logic [POS_W-1:0]  pos_inc;
   logic              hunt;
   logic              can_store;
   logic              tail_hit;
   logic              is_short;

   always_comb begin
      shifted   = {shift_ff[BYTE_W-1:0], rx_byte};
      hunt      = (pos_ff == '0) && (shift_ff != cfg.header_word);
      eff_limit = (cfg.buffer_limit > LIMIT_CAP_POS) ? LIMIT_CAP_POS : cfg.buffer_limit;
      can_store = pos_ff < eff_limit;
      pos_inc   = pos_ff + POS_W'(can_store);
      tail_hit  = !hunt && (shifted == cfg.tail_word);
      is_short  = pos_inc < TRAILER_BYTES;
   end

   always_comb begin
      result.data_byte  = rx_byte;
      result.byte_index = (pos_ff > INDEX_MAX_POS) ? INDEX_MAX_POS[INDEX_W-1:0]
                                                   : pos_ff[INDEX_W-1:0];
      result.stored     = can_store;
      result.frame_end  = tail_hit;
      result.short_frame = tail_hit && is_short;
      if (tail_hit && !is_short) begin
         result.payload_length = LENGTH_W'(pos_inc - TRAILER_BYTES);
      end else begin
         result.payload_length = '0;
      end
      has_result = !hunt;
   end

   always_comb begin
      shift_in = shift_ff;
      pos_in   = pos_ff;
      if (step) begin
         if (hunt) begin
            shift_in = shifted;
         end else if (tail_hit) begin
            shift_in = '0;
            pos_in   = '0;
         end else begin
            shift_in = shifted;
            pos_in   = pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         pos_ff   <= '0;
      end else begin
         shift_ff <= shift_in;
         pos_ff   <= pos_in;
      end
   end

   a_tail_clears: assert property (@(posedge clock) disable iff (reset)
      step && tail_hit |=> (pos_ff == '0) && (shift_ff == '0))
      else $error("frame end did not clear position and shift register");

   a_pos_capped: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LIMIT_CAP_POS)
      else $error("frame position beyond limit cap");

   a_hunt_holds_pos: assert property (@(posedge clock) disable iff (reset)
      step && hunt |=> pos_ff == '0)
      else $error("position moved while hunting for header");

endmodule

`default_nettype wire

/* hw/rtl/header_tail_frame_extractor.sv */
// Channel  | Dir | Handshake        | Payload
// ---------+-----+------------------+----------------------------------------------
// req_chan | in  | valid / ready    | rx_byte
// rsp_chan | out | valid / ready    | data_byte, byte_index, stored, frame_end,
//          |     |                  | payload_length, short_frame
// csr_*    | in  | csr_write_en     | csr_index (0 header, 1 tail, 2 limit), csr_wdata
//
// One request per cycle while the result register drains; an accepted request
// passes the input register, then a deframer step into the result register.
// Hunting bytes (no header lock yet) are consumed with no result.
// Reset (synchronous, active high) restores the default patterns and limit and
// clears the shift register and frame position.
// A stalled result register holds the request in the input register; the input
// side keeps accepting as long as the result register can drain this cycle.
`default_nettype none

module header_tail_frame_extractor (
   input  wire logic                              clock,
   input  wire logic                              reset,
   hte_req_if.sink                                req_chan,
   hte_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_write_en,
   input  wire logic [hte_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [hte_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hte_pkg::*;

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;

   // result register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   logic    out_free;
   logic    step;
   logic    req_take;
   logic    has_result;
   rsp_type result;

   // the result register can take a new value when empty or draining now
   assign out_free = !out_valid_ff || rsp_chan.ready;
   // the deframer consumes the held request whenever the result register can follow
   assign step     = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || step;
   assign req_take = req_chan.valid && req_chan.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_HEADER_WORD:  cfg_in.header_word  = csr_wdata;
            CSR_TAIL_WORD:    cfg_in.tail_word    = csr_wdata;
            CSR_BUFFER_LIMIT: cfg_in.buffer_limit = csr_wdata[POS_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_chan.rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   hte_deframer u_deframer (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .cfg        (cfg_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (step) begin
         out_valid_in = has_result;
         if (has_result) begin
            out_in = result;
         end
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_word  <= HEADER_WORD_RESET;
         cfg_ff.tail_word    <= TAIL_WORD_RESET;
         cfg_ff.buffer_limit <= BUFFER_LIMIT_RESET;
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.data_byte      = out_ff.data_byte;
   assign rsp_chan.byte_index     = out_ff.byte_index;
   assign rsp_chan.stored         = out_ff.stored;
   assign rsp_chan.frame_end      = out_ff.frame_end;
   assign rsp_chan.payload_length = out_ff.payload_length;
   assign rsp_chan.short_frame    = out_ff.short_frame;

   a_result_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without a held request");

   a_length_only_at_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.frame_end |-> (out_ff.payload_length == '0) && !out_ff.short_frame)
      else $error("length or short flag outside frame end");

   a_stall_holds_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_byte_ff))
      else $error("held request lost during result stall");

endmodule

`default_nettype wire
